// ===== hw/rtl/ierm_pkg.sv =====
// ierm_pkg: shared constants and types for the icmp echo reply matcher
// holds verdict codes, register indexes, header offsets and the parser view struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ierm_pkg;

  localparam int DEFAULT_MAX_PACKET_BYTES = 4096;

  localparam int MIN_IP_HEADER   = 20;
  localparam int ICMP_HEAD_BYTES = 8;

  localparam logic [7:0] ECHO_REPLY_TYPE = 8'd0;

  // offsets relative to the start of the icmp header
  localparam int ICMP_TYPE_OFF = 0;
  localparam int ICMP_ID_HI    = 4;
  localparam int ICMP_ID_LO    = 5;
  localparam int ICMP_SEQ_HI   = 6;
  localparam int ICMP_SEQ_LO   = 7;

  // configuration register indexes
  localparam logic [1:0] REG_EXP_ID  = 2'd0;
  localparam logic [1:0] REG_EXP_SEQ = 2'd1;

  // verdict codes
  localparam logic [1:0] VERDICT_SHORT    = 2'd0;
  localparam logic [1:0] VERDICT_NO_MATCH = 2'd1;
  localparam logic [1:0] VERDICT_MATCH    = 2'd2;

  // packet fields as they stand after the current byte
  typedef struct packed {
    logic        too_short;
    logic [7:0]  icmp_type;
    logic [15:0] identifier;
    logic [15:0] sequence_num;
  } pkt_view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ierm_parser.sv =====
// ierm_parser: per-packet byte counter and header field capture
// depends on ierm_pkg for offsets, minimum lengths and the pkt_view_t struct
`timescale 1ns / 1ps
`default_nettype none

module ierm_parser #(
  parameter int MAX_PACKET_BYTES = ierm_pkg::DEFAULT_MAX_PACKET_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                beat,
  input  wire logic [7:0]          packet_byte,
  input  wire logic                final_byte,
  output      ierm_pkg::pkt_view_t view
);

  import ierm_pkg::*;

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int SW = (CW > 7) ? CW : 7;

  logic [CW-1:0] bytes_seen;
  logic [CW-1:0] bytes_seen_next;
  logic [5:0]    ip_header_bytes;
  logic [5:0]    ip_header_bytes_next;
  logic [7:0]    captured_type;
  logic [7:0]    captured_type_next;
  logic [15:0]   captured_identifier;
  logic [15:0]   captured_identifier_next;
  logic [15:0]   captured_sequence;
  logic [15:0]   captured_sequence_next;

  logic          counting;
  logic [SW-1:0] pos_ext;
  logic [SW-1:0] hdr_ext;
  logic [SW-1:0] rel;
  logic          in_icmp;
  logic [SW-1:0] cnt_ext;

  always_comb begin
    counting = beat && (bytes_seen < CW'(MAX_PACKET_BYTES));

    // header length from byte 0 takes effect for byte 0 itself
    ip_header_bytes_next = ip_header_bytes;
    if (counting && (bytes_seen == '0)) begin
      ip_header_bytes_next = {packet_byte[3:0], 2'b00};
    end

    pos_ext = SW'(bytes_seen);
    hdr_ext = SW'(ip_header_bytes_next);
    rel     = pos_ext - hdr_ext;
    in_icmp = counting && (pos_ext >= hdr_ext);

    captured_type_next       = captured_type;
    captured_identifier_next = captured_identifier;
    captured_sequence_next   = captured_sequence;
    if (in_icmp) begin
      if (rel == SW'(ICMP_TYPE_OFF)) begin
        captured_type_next = packet_byte;
      end
      if (rel == SW'(ICMP_ID_HI)) begin
        captured_identifier_next[15:8] = packet_byte;
      end
      if (rel == SW'(ICMP_ID_LO)) begin
        captured_identifier_next[7:0] = packet_byte;
      end
      if (rel == SW'(ICMP_SEQ_HI)) begin
        captured_sequence_next[15:8] = packet_byte;
      end
      if (rel == SW'(ICMP_SEQ_LO)) begin
        captured_sequence_next[7:0] = packet_byte;
      end
    end

    bytes_seen_next = counting ? (bytes_seen + CW'(1)) : bytes_seen;
    cnt_ext         = SW'(bytes_seen_next);

    view.too_short    = (cnt_ext < SW'(MIN_IP_HEADER)) ||
                        (cnt_ext < (hdr_ext + SW'(ICMP_HEAD_BYTES)));
    view.icmp_type    = captured_type_next;
    view.identifier   = captured_identifier_next;
    view.sequence_num = captured_sequence_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (beat && final_byte)) begin
      bytes_seen          <= '0;
      ip_header_bytes     <= '0;
      captured_type       <= '0;
      captured_identifier <= '0;
      captured_sequence   <= '0;
    end else begin
      bytes_seen          <= bytes_seen_next;
      ip_header_bytes     <= ip_header_bytes_next;
      captured_type       <= captured_type_next;
      captured_identifier <= captured_identifier_next;
      captured_sequence   <= captured_sequence_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/icmp_echo_reply_matcher.sv =====
// icmp_echo_reply_matcher: top level, config registers, verdict and output register
// depends on ierm_pkg and ierm_parser
//
// usage:
//   the input channel (in_valid/in_ready, packet_byte, final_byte) takes one byte
//   of a received ipv4 packet per beat, in wire order, with final_byte set on the
//   last byte. only the beat carrying final_byte yields a result.
//   the output channel (out_valid/out_ready, verdict) gives one verdict per packet:
//   VERDICT_SHORT, VERDICT_NO_MATCH or VERDICT_MATCH (echo reply whose identifier
//   and sequence equal the configured values).
//   the config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   expected_identifier (index 0) and expected_sequence_number (index 1); other
//   indexes are dropped. cfg_ready is always high; write only while idle.
// timing:
//   one byte per cycle unless stalled; the verdict is on out_valid the cycle after
//   the final beat. the per-byte path is one counter compare and one field capture,
//   and the verdict is one 16-bit compare pair, all ahead of the output register.
// stalls and reset:
//   the single output register holds a verdict until taken; in_ready stays high
//   as long as the output register is empty or being drained this cycle.
//   synchronous reset clears packet state, the config registers and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_matcher #(
  parameter int MAX_PACKET_BYTES = ierm_pkg::DEFAULT_MAX_PACKET_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        final_byte,
  // verdict output
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  verdict,
  // register writes
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import ierm_pkg::*;

  logic        in_beat;
  logic [15:0] expected_identifier;
  logic [15:0] expected_sequence_number;
  pkt_view_t   view;
  logic [1:0]  verdict_next;

  // output register frees up whenever its contents leave this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  ierm_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .beat       (in_beat),
    .packet_byte(packet_byte),
    .final_byte (final_byte),
    .view       (view)
  );

  // config registers, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_identifier      <= '0;
      expected_sequence_number <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXP_ID:  expected_identifier      <= cfg_data;
        REG_EXP_SEQ: expected_sequence_number <= cfg_data;
        default: ;
      endcase
    end
  end

  // judge the packet on its fields as they stand after the final byte
  always_comb begin
    if (view.too_short) begin
      verdict_next = VERDICT_SHORT;
    end else if ((view.icmp_type == ECHO_REPLY_TYPE) &&
                 (view.identifier == expected_identifier) &&
                 (view.sequence_num == expected_sequence_number)) begin
      verdict_next = VERDICT_MATCH;
    end else begin
      verdict_next = VERDICT_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat && final_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat && final_byte) begin
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire
